// File: rtl/pidc_pkg.sv
// shared types, constants and fixed-point helpers for the pid controller
package pidc_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int AddrWidth = 5;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int AccWidth  = DataWidth + 2;

  typedef logic signed [DataWidth-1:0] word_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [AccWidth-1:0]  acc_t;

  // register index, byte address divided by four
  localparam logic [2:0] RegGainP    = 3'd0;
  localparam logic [2:0] RegGainI    = 3'd1;
  localparam logic [2:0] RegGainD    = 3'd2;
  localparam logic [2:0] RegTimeStep = 3'd3;
  localparam logic [2:0] RegInvStep  = 3'd4;
  localparam logic [2:0] RegOutMax   = 3'd5;
  localparam logic [2:0] RegOutMin   = 3'd6;

  localparam word_t WordMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataWidth-1){1'b0}}};

  typedef enum logic [2:0] {
    StIdle,
    StMulIts,
    StMulDif,
    StMulKp,
    StMulKi,
    StMulKd,
    StSum
  } state_e;

  // saturate a wide sum to one word
  function automatic word_t sat_acc(acc_t v);
    logic ovf;
    ovf = (v[AccWidth-1:DataWidth-1] != {(AccWidth-DataWidth+1){v[AccWidth-1]}});
    if (ovf) begin
      return v[AccWidth-1] ? WordMin : WordMax;
    end
    return v[DataWidth-1:0];
  endfunction

  // product shifted right with floor rounding, then saturated to one word
  function automatic word_t scale_sat(prod_t p);
    prod_t s;
    logic  ovf;
    s   = p >>> FracBits;
    ovf = (s[ProdWidth-1:DataWidth-1] != {(ProdWidth-DataWidth+1){s[ProdWidth-1]}});
    if (ovf) begin
      return s[ProdWidth-1] ? WordMin : WordMax;
    end
    return s[DataWidth-1:0];
  endfunction

endpackage

// File: rtl/pid_controller_clamped.sv
// discrete pid controller with output clamp, one shared multiplier
// Each transaction on the input channel (target, measured, signed Q16.16)
// yields exactly one transaction on the output channel (drive, clamped).
// The five products (error*dt, difference*inv_dt, and the three gain
// products) go one after another through a single 32x32 signed multiplier
// with a registered product, so an item passes through the accept state,
// one state per product, and a final state that adds the terms and clamps.
// in_stall_o is high after accept until the datapath is back in idle. The
// result is offered from the output register after the final add, and the
// next item can be accepted once the sequencer is back in idle. If the
// previous result is still stalled at the output, the final add waits for
// the output register to empty and the registered product holds meanwhile.
// The next item may be accepted while a finished result waits to be taken.
// Configuration registers sit on an APB-style port at byte addresses 4*i:
// gain_p, gain_i, gain_d, time_step, inv_time_step, out_max, out_min. They
// are to be written only while the block is idle; the user must keep to
// this, as the block itself does not enforce it. Integral and last error
// state reset to zero; there is no clearing pass.
module pid_controller_clamped
  import pidc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          target_i,
  input  logic [31:0]          measured_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          drive_o,
  output logic                 clamped_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // configuration registers
  word_t       gain_p_q, gain_i_q, gain_d_q, out_max_q, out_min_q;
  logic [30:0] time_step_q, inv_step_q;

  // datapath state
  state_e state_q, state_d;
  word_t  err_q, diff_q, deriv_q, integ_q, last_err_q;
  acc_t   acc_q;
  prod_t  prod_q;
  word_t  mul_a, mul_b, scaled;
  word_t  sum_sat;
  logic   out_valid_q;
  word_t  drive_q;
  logic   clamped_q;

  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic       in_acc, out_acc, sum_go;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  // register read back
  always_comb begin
    case (reg_idx)
      RegGainP:    prdata = gain_p_q;
      RegGainI:    prdata = gain_i_q;
      RegGainD:    prdata = gain_d_q;
      RegTimeStep: prdata = {1'b0, time_step_q};
      RegInvStep:  prdata = {1'b0, inv_step_q};
      RegOutMax:   prdata = out_max_q;
      RegOutMin:   prdata = out_min_q;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= 32'sd65536;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      time_step_q <= 31'd655;
      inv_step_q  <= 31'd6553600;
      out_max_q   <= 32'sd6553600;
      out_min_q   <= -32'sd6553600;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegGainP:    gain_p_q    <= pwdata;
        RegGainI:    gain_i_q    <= pwdata;
        RegGainD:    gain_d_q    <= pwdata;
        RegTimeStep: time_step_q <= pwdata[30:0];
        RegInvStep:  inv_step_q  <= pwdata[30:0];
        RegOutMax:   out_max_q   <= pwdata;
        RegOutMin:   out_min_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_q & ~out_stall_i;
  // the final add only fires once the output register is free
  assign sum_go     = (state_q == StSum) & (~out_valid_q | ~out_stall_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_acc) state_d = StMulIts;
      StMulIts: state_d = StMulDif;
      StMulDif: state_d = StMulKp;
      StMulKp:  state_d = StMulKi;
      StMulKi:  state_d = StMulKd;
      StMulKd:  state_d = StSum;
      StSum:    if (sum_go) state_d = StIdle;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = err_q;
    mul_b = $signed({1'b0, time_step_q});
    unique case (state_q)
      StMulDif: begin
        mul_a = diff_q;
        mul_b = $signed({1'b0, inv_step_q});
      end
      StMulKp: begin
        mul_a = gain_p_q;
        mul_b = err_q;
      end
      StMulKi: begin
        mul_a = gain_i_q;
        mul_b = integ_q;
      end
      StMulKd: begin
        mul_a = gain_d_q;
        mul_b = deriv_q;
      end
      default: ;
    endcase
  end

  // registered product, shifted and saturated
  assign scaled  = scale_sat(prod_q);
  assign sum_sat = sat_acc(acc_q + acc_t'(scaled));

  // payload path, operands hold through stalls by construction
  always_ff @(posedge clk_i) begin
    // the derivative term stays in the product register while the add waits
    if (state_q != StSum) begin
      prod_q <= mul_a * mul_b;
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          err_q <= sat_acc(acc_t'($signed(target_i)) - acc_t'($signed(measured_i)));
        end
      end
      StMulIts: diff_q  <= sat_acc(acc_t'(err_q) - acc_t'(last_err_q));
      StMulDif: ;
      StMulKp:  deriv_q <= scaled;
      StMulKi:  acc_q   <= acc_t'(scaled);
      StMulKd:  acc_q   <= acc_q + acc_t'(scaled);
      StSum: begin
        if (sum_go) begin
          // upper limit is tested first, also when limits are crossed
          if (sum_sat > out_max_q) begin
            drive_q   <= out_max_q;
            clamped_q <= 1'b1;
          end else if (sum_sat < out_min_q) begin
            drive_q   <= out_min_q;
            clamped_q <= 1'b1;
          end else begin
            drive_q   <= sum_sat;
            clamped_q <= 1'b0;
          end
        end
      end
    endcase
  end

  // controller state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else begin
      if (state_q == StMulIts) begin
        last_err_q <= err_q;
      end
      // integral takes error*dt from the product of the previous cycle
      if (state_q == StMulDif) begin
        integ_q <= sat_acc(acc_t'(integ_q) + acc_t'(scaled));
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_go) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

endmodule

// File: rtl/pidc_checker.sv
// port-level checker for the pid controller and its bind
module pidc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] drive_o,
  input logic        clamped_o,
  input logic        psel,
  input logic        pready
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // a stalled result keeps valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) && $stable(clamped_o))
    else $error("stalled output transaction changed");

  // the sequencer stays busy after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input accepted again too early");

  // a new result appears only at the end of a busy period
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a preceding item");

  // configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low during access");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);
